// File: design/ezr_pkg.sv
// Package with constants, types and helper functions for the Euler to rotation matrix block.
`timescale 1ns / 1ps
`default_nettype none
package ezr_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int OUT_FRAC       = 14;
    localparam int OUT_W          = 16;
    localparam int CORDIC_ITERS   = 30;
    localparam int CW             = 34;
    localparam int ZW             = 33;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        begin
            case (i)
                0:  t = 32'h20000000;
                1:  t = 32'h12E4051E;
                2:  t = 32'h09FB385B;
                3:  t = 32'h051111D4;
                4:  t = 32'h028B0D43;
                5:  t = 32'h0145D7E1;
                6:  t = 32'h00A2F61E;
                7:  t = 32'h00517C55;
                8:  t = 32'h0028BE53;
                9:  t = 32'h00145F2F;
                10: t = 32'h000A2F98;
                11: t = 32'h000517CC;
                12: t = 32'h00028BE6;
                13: t = 32'h000145F3;
                14: t = 32'h0000A2FA;
                15: t = 32'h0000517D;
                16: t = 32'h000028BE;
                17: t = 32'h0000145F;
                18: t = 32'h00000A30;
                19: t = 32'h00000518;
                20: t = 32'h0000028C;
                21: t = 32'h00000146;
                22: t = 32'h000000A3;
                23: t = 32'h00000051;
                24: t = 32'h00000029;
                25: t = 32'h00000014;
                26: t = 32'h0000000A;
                27: t = 32'h00000005;
                28: t = 32'h00000003;
                29: t = 32'h00000001;
                default: t = 32'h0;
            endcase
            return t;
        end
    endfunction

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } cordic_t;

endpackage
`default_nettype wire

// File: design/euler_zyx_to_rotation_matrix.sv
// Top level: ZYX Euler angles to transposed rotation matrix, fully pipelined.
//
// Input stream s_axis carries three binary angles (a full turn is 2^ANGLE_BITS);
// output stream m_axis carries the nine Q2.14 elements of the transposed
// product Rz*Ry*Rx in row-major order. One transfer is accepted per cycle
// unless m_axis stalls. The pipeline has one stage for the quadrant fold,
// one stage per CORDIC iteration, one for rounding the sines and cosines,
// two for each of the two matrix products (multiply, then sum and round)
// and one output stage. The three CORDIC pipelines run side by side.
// Every stage carries a valid bit; the whole pipeline advances only when the
// last stage is empty or its transfer is taken, so a stall on m_axis freezes
// all stages and nothing is lost or repeated. s_axis_tready falls whenever
// the last stage holds a transfer and m_axis_tready is low.
// Reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module euler_zyx_to_rotation_matrix #(
    parameter int ANGLE_BITS = ezr_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ezr_pkg::FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // angle_z [15:0], angle_y [31:16], angle_x [47:32]
    input  wire logic [47:0]   s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // e00, e01, e02, e10, e11, e12, e20, e21, e22, 16 bits each from the lowest bits up
    output logic [143:0]       m_axis_tdata
);
    import ezr_pkg::*;

    localparam int NS   = CORDIC_ITERS + 7;
    localparam int FW   = FRAC_BITS + 2;
    localparam int PW   = 2 * FW;
    localparam int SW   = PW + 2;
    localparam int RSH  = 30 - FRAC_BITS;
    localparam logic signed [FW-1:0] ONE_F = FW'(1) <<< FRAC_BITS;

    logic          adv;
    logic [NS-1:0] vld_reg;

    assign adv           = !vld_reg[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
        end
    end

    function automatic logic signed [FW-1:0] sat_f(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] lim;
        begin
            lim = SW'(1) <<< FRAC_BITS;
            if (v > lim)
                return ONE_F;
            else if (v < -lim)
                return -ONE_F;
            else
                return v[FW-1:0];
        end
    endfunction

    function automatic logic signed [FW-1:0] rnd_prod(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        begin
            r = (v + (SW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            return sat_f(r);
        end
    endfunction

    function automatic logic signed [FW-1:0] rnd_cordic(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            if (RSH == 0)
                r = v;
            else
                r = (v + (CW'(1) <<< (RSH - 1))) >>> RSH;
            return sat_f(SW'(r));
        end
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [FW-1:0] v);
        logic signed [SW+OUT_FRAC-1:0] w;
        logic signed [SW+OUT_FRAC-1:0] lim;
        begin
            lim = (SW+OUT_FRAC)'(1) <<< OUT_FRAC;
            if (FRAC_BITS >= OUT_FRAC)
            begin
                if (FRAC_BITS == OUT_FRAC)
                    w = (SW+OUT_FRAC)'(v);
                else
                    w = ((SW+OUT_FRAC)'(v)
                        + ((SW+OUT_FRAC)'(1) <<< (FRAC_BITS - OUT_FRAC - 1)))
                        >>> (FRAC_BITS - OUT_FRAC);
            end
            else
            begin
                w = (SW+OUT_FRAC)'(v) <<< ((OUT_FRAC - FRAC_BITS) & 31);
            end
            if (w > lim)
                w = lim;
            else if (w < -lim)
                w = -lim;
            return w[OUT_W-1:0];
        end
    endfunction

    // CORDIC pipelines, one per angle.
    logic signed [FW-1:0] sn [3];
    logic signed [FW-1:0] cs [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_ang
        cordic_t          st_reg [CORDIC_ITERS+1];
        logic [31:0]      t;
        logic [31:0]      tf;
        logic             fl;
        logic signed [FW-1:0] s_reg, c_reg;
        logic signed [CW-1:0] xo, yo;

        always_comb
        begin
            t  = (32'(s_axis_tdata[16*a +: 16]) & ~(32'hFFFF_FFFF << ANGLE_BITS))
                 << (32 - ANGLE_BITS);
            fl = (t + 32'h4000_0000) >> 31 != 32'd0;
            tf = fl ? t + 32'h8000_0000 : t;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[0].x    <= CORDIC_GAIN_Q30;
                st_reg[0].y    <= '0;
                st_reg[0].z    <= ZW'(signed'(tf));
                st_reg[0].flip <= fl;
            end
        end

        for (genvar i = 0; i < CORDIC_ITERS; i++)
        begin : g_it
            logic signed [CW-1:0] dx, dy;
            logic signed [ZW-1:0] at;
            assign dx = st_reg[i].y >>> i;
            assign dy = st_reg[i].x >>> i;
            assign at = ZW'(atan_turn(i));
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    st_reg[i+1].flip <= st_reg[i].flip;
                    if (!st_reg[i].z[ZW-1])
                    begin
                        st_reg[i+1].x <= st_reg[i].x - dx;
                        st_reg[i+1].y <= st_reg[i].y + dy;
                        st_reg[i+1].z <= st_reg[i].z - at;
                    end
                    else
                    begin
                        st_reg[i+1].x <= st_reg[i].x + dx;
                        st_reg[i+1].y <= st_reg[i].y - dy;
                        st_reg[i+1].z <= st_reg[i].z + at;
                    end
                end
            end
        end

        assign xo = st_reg[CORDIC_ITERS].flip ? -st_reg[CORDIC_ITERS].x
                                              : st_reg[CORDIC_ITERS].x;
        assign yo = st_reg[CORDIC_ITERS].flip ? -st_reg[CORDIC_ITERS].y
                                              : st_reg[CORDIC_ITERS].y;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_reg <= rnd_cordic(xo);
                s_reg <= rnd_cordic(yo);
            end
        end
        assign sn[a] = s_reg;
        assign cs[a] = c_reg;
    end

    // Ry*Rx products. Terms: m00=cy, m01=-sy*sx, m02=-sy*cx,
    // m10=0, m11=cx, m12=-sx, m20=sy, m21=cy*sx, m22=cy*cx.
    logic signed [PW-1:0] p1_reg [4];
    logic signed [FW-1:0] sz1_reg, cz1_reg, cy1_reg, sy1_reg, cx1_reg, sx1_reg;
    logic signed [FW-1:0] m_reg [9];
    logic signed [FW-1:0] sz2_reg, cz2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg[0] <= sn[1] * sn[2];
            p1_reg[1] <= sn[1] * cs[2];
            p1_reg[2] <= cs[1] * sn[2];
            p1_reg[3] <= cs[1] * cs[2];
            sz1_reg <= sn[0];
            cz1_reg <= cs[0];
            sy1_reg <= sn[1];
            cy1_reg <= cs[1];
            sx1_reg <= sn[2];
            cx1_reg <= cs[2];

            m_reg[0] <= cy1_reg;
            m_reg[1] <= rnd_prod(-SW'(p1_reg[0]));
            m_reg[2] <= rnd_prod(-SW'(p1_reg[1]));
            m_reg[3] <= '0;
            m_reg[4] <= cx1_reg;
            m_reg[5] <= -sx1_reg;
            m_reg[6] <= sy1_reg;
            m_reg[7] <= rnd_prod(SW'(p1_reg[2]));
            m_reg[8] <= rnd_prod(SW'(p1_reg[3]));
            sz2_reg <= sz1_reg;
            cz2_reg <= cz1_reg;
        end
    end

    // Rz*M: row0 = cz*m0j - sz*m1j, row1 = sz*m0j + cz*m1j, row2 = m2j.
    logic signed [PW-1:0] q_reg [12];
    logic signed [FW-1:0] r2_reg [3];
    logic signed [FW-1:0] pr_reg [9];
    logic [OUT_W-1:0]     o_reg [9];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                q_reg[j]     <= cz2_reg * m_reg[j];
                q_reg[3 + j] <= sz2_reg * m_reg[3 + j];
                q_reg[6 + j] <= sz2_reg * m_reg[j];
                q_reg[9 + j] <= cz2_reg * m_reg[3 + j];
                r2_reg[j]    <= m_reg[6 + j];
            end
            for (int j = 0; j < 3; j++)
            begin
                pr_reg[j]     <= rnd_prod(SW'(q_reg[j]) - SW'(q_reg[3 + j]));
                pr_reg[3 + j] <= rnd_prod(SW'(q_reg[6 + j]) + SW'(q_reg[9 + j]));
                pr_reg[6 + j] <= r2_reg[j];
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    o_reg[r * 3 + c] <= to_out(pr_reg[c * 3 + r]);
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m_axis_tdata[16*k +: 16] = o_reg[k];
        end
    end

endmodule
`default_nettype wire

// File: test/ezr_checker.sv
// Checker that predicts and compares the rotation matrix results of the Euler angle block.
`timescale 1ns / 1ps
`default_nettype none
module ezr_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [47:0]  s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [143:0] m_axis_tdata,
    output int                fail_count,
    output int                pending
);
    import ezr_pkg::*;

    localparam longint ONE = 64'sd1 << FRAC_BITS_DEF;

    logic [143:0] matrix_q[$];

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic void angle_sincos(input logic [15:0] ang, output longint s,
                                         output longint c);
        logic [31:0] t;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        t = {ang, 16'h0};
        flip = t[31] ^ t[30];
        if (flip)
            t = t + 32'h80000000;
        x = 652032874;
        y = 0;
        z = longint'(signed'(t));
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_turn(i));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_turn(i));
            end
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        c = clamp(round_sh(x, 30 - FRAC_BITS_DEF), ONE);
        s = clamp(round_sh(y, 30 - FRAC_BITS_DEF), ONE);
    endfunction

    function automatic logic [143:0] rotation_of(logic [47:0] angles);
        longint sz, cz, sy, cy, sx, cx, acc;
        longint rz[3][3], ry[3][3], rx[3][3], mid[3][3], prod[3][3];
        logic [143:0] res;
        angle_sincos(angles[15:0], sz, cz);
        angle_sincos(angles[31:16], sy, cy);
        angle_sincos(angles[47:32], sx, cx);
        rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, ONE}};
        ry = '{'{cy, 0, -sy}, '{0, ONE, 0}, '{sy, 0, cy}};
        rx = '{'{ONE, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                acc = ry[r][0] * rx[0][c] + ry[r][1] * rx[1][c] + ry[r][2] * rx[2][c];
                mid[r][c] = clamp(round_sh(acc, FRAC_BITS_DEF), ONE);
            end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                acc = rz[r][0] * mid[0][c] + rz[r][1] * mid[1][c] + rz[r][2] * mid[2][c];
                prod[r][c] = clamp(round_sh(acc, FRAC_BITS_DEF), ONE);
            end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                res[(r*3+c)*16 +: 16] = 16'(clamp(prod[c][r], 64'sd1 << OUT_FRAC));
        return res;
    endfunction

    string elem_name[9] = '{"e00", "e01", "e02", "e10", "e11", "e12", "e20", "e21", "e22"};

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge clk)
    begin
        logic [143:0] want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            matrix_q.push_back(rotation_of(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (matrix_q.size() == 0)
            begin
                $error("result transfer with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = matrix_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (want[k*16 +: 16] !== m_axis_tdata[k*16 +: 16])
                    begin
                        $error("%s expected %0d actual %0d", elem_name[k],
                               $signed(want[k*16 +: 16]), $signed(m_axis_tdata[k*16 +: 16]));
                        fail_count++;
                    end
            end
        end
        pending = matrix_q.size();
    end
endmodule
`default_nettype wire

// File: test/tb_euler_zyx_to_rotation_matrix.sv
// Testbench top that drives angle transfers into the Euler angle block and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_euler_zyx_to_rotation_matrix;
    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [143:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    bit           calm = 0;
    bit           hold_off = 0;

    always #5 clk = ~clk;

    euler_zyx_to_rotation_matrix u_top (.*);

    ezr_checker u_chk (.*);

    always @(negedge clk)
        m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 14);

    task automatic send_angles(input logic [15:0] az, input logic [15:0] ay,
                               input logic [15:0] ax);
        while (!calm && $urandom_range(99) < 14)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {ax, ay, az};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_angle();
        logic [15:0] special[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                                     16'h3FFF, 16'h4001, 16'h7FFF, 16'h2000, 16'h0001};
        if ($urandom_range(3) == 0)
            return special[$urandom_range(9)];
        return 16'($urandom);
    endfunction

    initial
    begin
        logic [15:0] edge_ang[10];
        edge_ang = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                     16'h3FFF, 16'hBFFF, 16'h7FFF, 16'h0001, 16'h5555};
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        for (int i = 0; i < 10; i++)
            send_angles(edge_ang[i], edge_ang[(i + 3) % 10], edge_ang[(i + 7) % 10]);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_angles(16'h2000, 16'h2000, 16'h2000);
        fork
            begin
                hold_off = 1;
                repeat (120) @(negedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 60; i++)
                send_angles(16'($urandom), 16'($urandom), 16'($urandom));
        join
        s_axis_tvalid <= 0;
        while (pending != 0)
            @(negedge clk);
        for (int i = 0; i < 430; i++)
        begin
            calm = (i >= 150 && i < 230);
            send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        s_axis_tvalid <= 0;
        calm = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
